[rtl/dmtt_pkg.sv]
// Shared types, constants and score arithmetic for the direct-mapped
// transposition table. No dependencies; imported by dmtt_ctrl, dmtt_dpath and the top level.
package dmtt_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 65536;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // Field widths
  localparam int KEY_W   = 64;
  localparam int MOVE_W  = 16;
  localparam int SCORE_W = 16;
  localparam int PLY_W   = 8;
  localparam int DEPTH_W = 8;
  localparam int BOUND_W = 2;
  localparam int THR_W   = 15;
  localparam int ENT_W   = 17;
  localparam int HALF_W  = KEY_W / 2;
  localparam int PROD_W  = HALF_W + ENT_W;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = ENT_W;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENTRIES = 1'b1;

  localparam logic [THR_W-1:0] WIN_THRESHOLD_RST = THR_W'(30000);
  localparam logic [ENT_W-1:0] TABLE_ENTRIES_RST = ENT_W'(65536);

  // Input action codes
  localparam logic ACT_PROBE = 1'b0;
  localparam logic ACT_STORE = 1'b1;

  // One table slot
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [MOVE_W-1:0]  move;
    logic [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0] depth;
    logic [BOUND_W-1:0] bound;
  } dmtt_entry_t;

  localparam int ENTRY_W = $bits(dmtt_entry_t);

  // Controller -> datapath
  typedef struct packed {
    logic capture;
    logic mem_write;
    logic mem_read;
    logic clear_write;
    logic out_load;
  } dmtt_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic is_store;
    logic out_free;
  } dmtt_stat_t;

  // Win-score ply adjustment: away from zero (store) or toward zero (probe),
  // saturated to 16 bits. Non-win scores pass unchanged.
  function automatic logic [SCORE_W-1:0] score_adjust(
    input logic [SCORE_W-1:0] s,
    input logic [PLY_W-1:0]   ply,
    input logic [THR_W-1:0]   thr,
    input logic               away
  );
    logic signed [SCORE_W:0]   sx;
    logic        [SCORE_W:0]   mag;
    logic                      win;
    logic signed [SCORE_W+1:0] pext;
    logic signed [SCORE_W+1:0] step;
    logic signed [SCORE_W+1:0] sum;
    logic        [SCORE_W-1:0] sat;
    sx   = $signed({s[SCORE_W-1], s});
    mag  = s[SCORE_W-1] ? (SCORE_W+1)'(-sx) : (SCORE_W+1)'(sx);
    win  = (mag >= {2'b00, thr});
    pext = $signed({{(SCORE_W+2-PLY_W){1'b0}}, ply});
    step = s[SCORE_W-1] ? -pext : pext;
    sum  = away ? ($signed({{2{s[SCORE_W-1]}}, s}) + step)
                : ($signed({{2{s[SCORE_W-1]}}, s}) - step);
    if (sum > $signed((SCORE_W+2)'(32767))) begin
      sat = 16'h7FFF;
    end else if (sum < -$signed((SCORE_W+2)'(32768))) begin
      sat = 16'h8000;
    end else begin
      sat = sum[SCORE_W-1:0];
    end
    return win ? sat : s;
  endfunction

endpackage

[rtl/dmtt_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module dmtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One address per cycle: write, registered read, or both
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/dmtt_ctrl.sv]
// Controller FSM: clearing sweep, transaction accept, table access sequencing.
// Depends on dmtt_pkg.
module dmtt_ctrl
  import dmtt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dmtt_stat_t stat,
  output dmtt_cmd_t  cmd
);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_INDEX  = 2'd2;
  localparam logic [1:0] S_LOOKUP = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_write = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_INDEX;
        end
      end
      S_INDEX: begin
        if (stat.is_store) begin
          cmd.mem_write = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.mem_read = 1'b1;
          state_nxt    = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        // hold the read data until the output register frees up
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // One transaction in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  a_lookup_after_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOKUP) |-> ($past(state_r) == S_INDEX || $past(state_r) == S_LOOKUP))
    else $error("lookup entered without a table read");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded over an untaken result");

endmodule

[rtl/dmtt_dpath.sv]
// Datapath: config registers, slot index multiply, table RAM, score adjust,
// result register. Depends on dmtt_pkg and dmtt_ram.
module dmtt_dpath
  import dmtt_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        in_action,
  input  logic [KEY_W-1:0]            in_key,
  input  logic [PLY_W-1:0]            in_ply,
  input  logic [MOVE_W-1:0]           in_move,
  input  logic signed [SCORE_W-1:0]   in_score,
  input  logic [DEPTH_W-1:0]          in_depth,
  input  logic [BOUND_W-1:0]          in_bound,
  input  dmtt_cmd_t                   cmd,
  output dmtt_stat_t                  stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic [MOVE_W-1:0]           out_found_move,
  output logic signed [SCORE_W-1:0]   out_found_score,
  output logic [DEPTH_W-1:0]          out_found_depth,
  output logic [BOUND_W-1:0]          out_found_bound
);

  // Configuration registers
  logic [THR_W-1:0] win_thr_r;
  logic [ENT_W-1:0] entries_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_thr_r <= WIN_THRESHOLD_RST;
      entries_r <= TABLE_ENTRIES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIN_THRESHOLD: win_thr_r <= cfg_data[THR_W-1:0];
        CFG_TABLE_ENTRIES: entries_r <= cfg_data[ENT_W-1:0];
        default: ;
      endcase
    end
  end

  // Entry count clamped to the table depth
  logic [ENT_W-1:0] n_eff;
  assign n_eff = (32'(entries_r) > 32'(TABLE_DEPTH)) ? ENT_W'(TABLE_DEPTH) : entries_r;

  // Captured transaction and partial products of key * n
  logic               action_r;
  logic [KEY_W-1:0]   key_r;
  logic [PLY_W-1:0]   ply_r;
  logic [MOVE_W-1:0]  move_r;
  logic [SCORE_W-1:0] score_r;
  logic [DEPTH_W-1:0] depth_r;
  logic [BOUND_W-1:0] bound_r;
  logic [PROD_W-1:0]  lo_prod_r;
  logic [PROD_W-1:0]  hi_prod_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r  <= in_action;
      key_r     <= in_key;
      ply_r     <= in_ply;
      move_r    <= in_move;
      score_r   <= in_score;
      depth_r   <= in_depth;
      bound_r   <= in_bound;
      lo_prod_r <= PROD_W'(in_key[HALF_W-1:0] * n_eff);
      hi_prod_r <= PROD_W'(in_key[KEY_W-1:HALF_W] * n_eff);
    end
  end

  // Slot index: high word of the 81-bit product
  logic [PROD_W:0]        prod_sum;
  logic [PROD_W-HALF_W:0] idx_full;
  logic [IDX_W-1:0]       slot;

  assign prod_sum = {1'b0, hi_prod_r} + (PROD_W+1)'(lo_prod_r[PROD_W-1:HALF_W]);
  assign idx_full = prod_sum[PROD_W:HALF_W];
  assign slot     = (32'(idx_full) >= 32'(TABLE_DEPTH)) ? '0 : idx_full[IDX_W-1:0];

  // Clearing sweep counter
  logic [IDX_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_write) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Table memory
  dmtt_entry_t wr_entry;
  dmtt_entry_t rd_entry;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [IDX_W-1:0]   ram_addr;

  always_comb begin
    wr_entry = '0;
    if (!cmd.clear_write) begin
      wr_entry.key   = key_r;
      wr_entry.move  = move_r;
      wr_entry.score = score_adjust(score_r, ply_r, win_thr_r, 1'b1);
      wr_entry.depth = depth_r;
      wr_entry.bound = bound_r;
    end
  end

  assign ram_addr = cmd.clear_write ? clr_cnt_r : slot;
  assign rd_entry = dmtt_entry_t'(ram_rdata);

  dmtt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.mem_write | cmd.clear_write),
    .re    (cmd.mem_read),
    .addr  (ram_addr),
    .wdata (wr_entry),
    .rdata (ram_rdata)
  );

  // Probe result register
  logic               out_valid_r;
  logic               out_hit_r;
  logic [MOVE_W-1:0]  out_move_r;
  logic [SCORE_W-1:0] out_score_r;
  logic [DEPTH_W-1:0] out_depth_r;
  logic [BOUND_W-1:0] out_bound_r;
  logic               hit;

  assign hit = (rd_entry.key == key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_hit_r   <= hit;
      out_move_r  <= hit ? rd_entry.move : '0;
      out_score_r <= hit ? score_adjust(rd_entry.score, ply_r, win_thr_r, 1'b0) : '0;
      out_depth_r <= hit ? rd_entry.depth : '0;
      out_bound_r <= hit ? rd_entry.bound : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_found_move  = out_move_r;
  assign out_found_score = out_score_r;
  assign out_found_depth = out_depth_r;
  assign out_found_bound = out_bound_r;

  // Status to the controller
  assign stat.clear_last = (clr_cnt_r == IDX_W'(TABLE_DEPTH - 1));
  assign stat.is_store   = (action_r == ACT_STORE);
  assign stat.out_free   = !out_valid_r || out_ready;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hit_r) |->
      (out_move_r == '0 && out_score_r == '0 && out_depth_r == '0 && out_bound_r == '0))
    else $error("miss result carries nonzero fields");

endmodule

[rtl/direct_mapped_transposition_table_unit.sv]
// Direct-mapped, always-replace transposition table, top level.
// Depends on dmtt_pkg, dmtt_ctrl, dmtt_dpath (which holds dmtt_ram).
//
// Usage:
//  - Input channel (in_valid/in_ready): in_action selects probe or store;
//    in_key picks the slot as the high word of key * entries in use.
//  - Result channel (out_valid/out_ready): one result per probe, none per
//    store. A miss returns hit 0 and all-zero fields.
//  - Config port (cfg_we/cfg_index/cfg_data): index 0 is the win-score
//    threshold, index 1 the entries in use; write only while idle.
//  - One transaction at a time. A store steps through capture with the
//    index multiply, then the table write. A probe steps through capture,
//    table read, then compare/adjust into the result register, where
//    out_valid rises. The single table RAM port and the split 64x17
//    index multiply set these steps.
//  - A new transaction is accepted while a result waits; a following probe
//    holds its read data until the receiver takes the older result.
//  - After reset the table is cleared one slot per cycle, with in_ready
//    low. Config writes are taken during the sweep.
module direct_mapped_transposition_table_unit
  import dmtt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_action,
  input  logic [KEY_W-1:0]          in_key,
  input  logic [PLY_W-1:0]          in_ply,
  input  logic [MOVE_W-1:0]         in_move,
  input  logic signed [SCORE_W-1:0] in_score,
  input  logic [DEPTH_W-1:0]        in_depth,
  input  logic [BOUND_W-1:0]        in_bound,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_hit,
  output logic [MOVE_W-1:0]         out_found_move,
  output logic signed [SCORE_W-1:0] out_found_score,
  output logic [DEPTH_W-1:0]        out_found_depth,
  output logic [BOUND_W-1:0]        out_found_bound
);

  dmtt_cmd_t  cmd;
  dmtt_stat_t stat;

  dmtt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dmtt_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_action       (in_action),
    .in_key          (in_key),
    .in_ply          (in_ply),
    .in_move         (in_move),
    .in_score        (in_score),
    .in_depth        (in_depth),
    .in_bound        (in_bound),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_found_move  (out_found_move),
    .out_found_score (out_found_score),
    .out_found_depth (out_found_depth),
    .out_found_bound (out_found_bound)
  );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for direct_mapped_transposition_table_unit.
// Depends on dmtt_pkg and the unit's rtl; predicts every probe result in-line.
module tb_top;
  import dmtt_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;  // covers the post-reset clearing sweep
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 6;

  // One request transaction on the input channel
  typedef struct {
    logic                      action;
    logic [KEY_W-1:0]          key;
    logic [PLY_W-1:0]          ply;
    logic [MOVE_W-1:0]         move;
    logic signed [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0]        depth;
    logic [BOUND_W-1:0]        bound;
  } tt_request_t;

  // One probe result
  typedef struct packed {
    logic                      hit;
    logic [MOVE_W-1:0]         move;
    logic signed [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0]        depth;
    logic [BOUND_W-1:0]        bound;
  } probe_result_t;

  // Shadow copy of one table slot
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [MOVE_W-1:0]  move;
    logic [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0] depth;
    logic [BOUND_W-1:0] bound;
  } slot_entry_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_action = ACT_PROBE;
  logic [KEY_W-1:0]          in_key = '0;
  logic [PLY_W-1:0]          in_ply = '0;
  logic [MOVE_W-1:0]         in_move = '0;
  logic signed [SCORE_W-1:0] in_score = '0;
  logic [DEPTH_W-1:0]        in_depth = '0;
  logic [BOUND_W-1:0]        in_bound = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      out_hit;
  logic [MOVE_W-1:0]         out_found_move;
  logic signed [SCORE_W-1:0] out_found_score;
  logic [DEPTH_W-1:0]        out_found_depth;
  logic [BOUND_W-1:0]        out_found_bound;

  direct_mapped_transposition_table_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_key          (in_key),
    .in_ply          (in_ply),
    .in_move         (in_move),
    .in_score        (in_score),
    .in_depth        (in_depth),
    .in_bound        (in_bound),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_found_move  (out_found_move),
    .out_found_score (out_found_score),
    .out_found_depth (out_found_depth),
    .out_found_bound (out_found_bound)
  );

  // Shadow state and bookkeeping
  logic [THR_W-1:0]  win_thr_model = WIN_THRESHOLD_RST;
  logic [ENT_W-1:0]  entries_model = TABLE_ENTRIES_RST;
  slot_entry_t       slot_model[int unsigned];
  tt_request_t       pending_requests[$];
  probe_result_t     expected_probes[$];
  logic [KEY_W-1:0]  key_pool[$];
  int                queued_requests = 0;
  int                accepted_requests = 0;
  int                mismatch_count = 0;
  int                idle_cycles = 0;
  int unsigned       send_gap = 0;
  int unsigned       recv_wait = 0;
  bit                in_taken = 1'b0;
  bit                out_taken = 1'b0;
  bit                tight_sender = 1'b0;
  bit                tight_receiver = 1'b0;
  bit                hold_request = 1'b0;
  tt_request_t       drive_rq;
  tt_request_t       seen_rq;
  probe_result_t     seen_exp;

  initial begin
    forever #4 clk = ~clk;
  end

  // Slot = high word of key * entries in use (clamped to the table size)
  function automatic int unsigned slot_index(input logic [KEY_W-1:0] k);
    logic [ENT_W-1:0]         n;
    logic [KEY_W+ENT_W-1:0]   prod;
    n = (entries_model > TABLE_DEPTH) ? ENT_W'(TABLE_DEPTH) : entries_model;
    prod = {{ENT_W{1'b0}}, k} * {{KEY_W{1'b0}}, n};
    if (prod[KEY_W+ENT_W-1:KEY_W] >= TABLE_DEPTH) return 0;
    return 32'(prod[KEY_W+ENT_W-1:KEY_W]);
  endfunction

  // Win scores move away from zero on store, toward zero on probe; saturated
  function automatic logic signed [SCORE_W-1:0] adjust_score(
    input logic signed [SCORE_W-1:0] s,
    input logic [PLY_W-1:0]          ply,
    input logic                      away
  );
    int sv;
    int mag;
    int adjusted;
    sv = int'(s);
    mag = (sv < 0) ? -sv : sv;
    if (mag < int'(win_thr_model)) return s;
    adjusted = (away ^ (sv < 0)) ? sv + int'(ply) : sv - int'(ply);
    if (adjusted > 32767) adjusted = 32767;
    if (adjusted < -32768) adjusted = -32768;
    return SCORE_W'(adjusted);
  endfunction

  // Apply one accepted transaction to the shadow table
  function automatic void predict_access(input tt_request_t rq);
    int unsigned   idx;
    slot_entry_t   e;
    probe_result_t r;
    idx = slot_index(rq.key);
    if (rq.action == ACT_STORE) begin
      e.key   = rq.key;
      e.move  = rq.move;
      e.score = adjust_score(rq.score, rq.ply, 1'b1);
      e.depth = rq.depth;
      e.bound = rq.bound;
      slot_model[idx] = e;
    end else begin
      if (slot_model.exists(idx)) e = slot_model[idx];
      else e = '0;
      r = '0;
      if (e.key == rq.key) begin
        r.hit   = 1'b1;
        r.move  = e.move;
        r.score = adjust_score(e.score, rq.ply, 1'b0);
        r.depth = e.depth;
        r.bound = e.bound;
      end
      expected_probes.push_back(r);
    end
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Monitor: handshakes sampled at the rising edge; check results, predict requests
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_valid && in_ready;
      out_taken <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        if (expected_probes.size() == 0) begin
          $display("%0t: unexpected result, expected none, got hit=%0b score=%0h",
                   $time, out_hit, out_found_score);
          mismatch_count++;
        end else begin
          seen_exp = expected_probes.pop_front();
          check_field("hit", 64'(seen_exp.hit), 64'(out_hit));
          check_field("found_move", 64'(seen_exp.move), 64'(out_found_move));
          check_field("found_score", 64'(unsigned'(seen_exp.score)),
                      64'(unsigned'(out_found_score)));
          check_field("found_depth", 64'(seen_exp.depth), 64'(out_found_depth));
          check_field("found_bound", 64'(seen_exp.bound), 64'(out_found_bound));
        end
      end
      if (in_valid && in_ready) begin
        seen_rq.action = in_action;
        seen_rq.key    = in_key;
        seen_rq.ply    = in_ply;
        seen_rq.move   = in_move;
        seen_rq.score  = in_score;
        seen_rq.depth  = in_depth;
        seen_rq.bound  = in_bound;
        predict_access(seen_rq);
        accepted_requests++;
      end
    end
  end

  // Watchdog: cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("direct_mapped_transposition_table_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Request driver: next transaction after a random gap
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_taken) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        drive_rq = pending_requests.pop_front();
        in_action <= drive_rq.action;
        in_key    <= drive_rq.key;
        in_ply    <= drive_rq.ply;
        in_move   <= drive_rq.move;
        in_score  <= drive_rq.score;
        in_depth  <= drive_rq.depth;
        in_bound  <= drive_rq.bound;
        in_valid  <= 1'b1;
        send_gap  <= tight_sender ? 0 : $urandom_range(0, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall after each taken result unless tight, plus one long hold
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      recv_wait <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (out_taken) begin
      recv_wait <= tight_receiver ? 0 : $urandom_range(0, 13);
      out_ready <= tight_receiver;
    end else if (recv_wait != 0) begin
      recv_wait <= recv_wait - 1;
      out_ready <= (recv_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == CFG_WIN_THRESHOLD) win_thr_model = data[THR_W-1:0];
    else entries_model = data[ENT_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send(input logic act, input logic [KEY_W-1:0] k,
                      input logic [PLY_W-1:0] ply, input logic [MOVE_W-1:0] mv,
                      input logic signed [SCORE_W-1:0] sc,
                      input logic [DEPTH_W-1:0] dp, input logic [BOUND_W-1:0] bd);
    tt_request_t rq;
    rq.action = act;
    rq.key    = k;
    rq.ply    = ply;
    rq.move   = mv;
    rq.score  = sc;
    rq.depth  = dp;
    rq.bound  = bd;
    pending_requests.push_back(rq);
    queued_requests++;
    if (act == ACT_STORE) begin
      key_pool.push_back(k);
      if (key_pool.size() > 48) void'(key_pool.pop_front());
    end
  endtask

  // Scores biased toward the threshold edge and saturation
  function automatic logic signed [SCORE_W-1:0] pick_score();
    int v;
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: v = int'($urandom_range(0, 200)) - 100;
      1: v = int'(win_thr_model) + int'($urandom_range(0, 4)) - 2;
      2: v = 32767 - int'($urandom_range(0, 300));
      3: begin
        case ($urandom_range(0, 2))
          0: v = -32768;
          1: v = 32767;
          default: v = -32767;
        endcase
      end
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if ((sel == 1 || sel == 2) && $urandom_range(0, 1) == 1) v = -v;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return SCORE_W'(v);
  endfunction

  // Random stores and probes, probes mostly on stored keys, plus slot collisions and misses
  task automatic send_random();
    logic [KEY_W-1:0] k;
    logic [PLY_W-1:0] ply;
    int               pick;
    pick = $urandom_range(0, 99);
    k = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: ply = '0;
      1: ply = '1;
      default: ply = PLY_W'($urandom_range(0, 255));
    endcase
    if (pick < 40) begin
      if (key_pool.size() != 0 && $urandom_range(0, 2) == 0)
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      send(ACT_STORE, k, ply, MOVE_W'($urandom), pick_score(), DEPTH_W'($urandom),
           BOUND_W'($urandom));
    end else begin
      if (pick < 80 && key_pool.size() != 0)
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else if (pick < 90 && key_pool.size() != 0)
        k = key_pool[$urandom_range(0, key_pool.size() - 1)] ^ 64'($urandom_range(1, 255));
      else if (pick >= 95)
        k = '0;
      send(ACT_PROBE, k, ply, MOVE_W'($urandom), pick_score(), DEPTH_W'($urandom),
           BOUND_W'($urandom));
    end
  endtask

  // Block until every request is taken and every result checked
  task automatic wait_for_drain();
    while (accepted_requests != queued_requests || expected_probes.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input int thr, input int ents, input int n_items,
                           input bit tight_tx, input bit tight_rx, input bit long_hold);
    write_cfg(CFG_WIN_THRESHOLD, CFG_DATA_W'(thr));
    write_cfg(CFG_TABLE_ENTRIES, CFG_DATA_W'(ents));
    tight_sender   = tight_tx;
    tight_receiver = tight_rx;
    repeat (n_items) send_random();
    if (long_hold) hold_request = 1'b1;
    wait_for_drain();
  endtask

  // Stimulus sequence
  initial begin
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: cleared slot, misses, win adjust both ways, saturation, collisions
    send(ACT_PROBE, '0, 8'd0, '0, '0, '0, '0);
    send(ACT_PROBE, '1, 8'd255, '0, '0, '0, '0);
    send(ACT_STORE, 64'h0123_4567_89AB_CDEF, 8'd255, 16'hFFFF, 16'sd30000, 8'hFF, 2'd3);
    send(ACT_PROBE, 64'h0123_4567_89AB_CDEF, 8'd255, '0, '0, '0, '0);
    send(ACT_PROBE, 64'h0123_4567_89AB_CDEF, 8'd0, '0, '0, '0, '0);
    send(ACT_STORE, 64'hFEDC_BA98_7654_3210, 8'd10, 16'h0001, -16'sd32768, 8'h01, 2'd2);
    send(ACT_PROBE, 64'hFEDC_BA98_7654_3210, 8'd255, '0, '0, '0, '0);
    send(ACT_STORE, 64'h8000_0000_0000_0001, 8'd1, 16'h8000, 16'sd32767, 8'h80, 2'd1);
    send(ACT_PROBE, 64'h8000_0000_0000_0001, 8'd0, '0, '0, '0, '0);
    send(ACT_STORE, 64'h5555_AAAA_5555_AAAA, 8'd200, 16'h1234, 16'sd29999, 8'h7F, 2'd0);
    send(ACT_PROBE, 64'h5555_AAAA_5555_AAAA, 8'd200, '0, '0, '0, '0);
    send(ACT_STORE, 64'hAAAA_5555_AAAA_5555, 8'd7, 16'h5A5A, -16'sd30000, 8'h55, 2'd2);
    send(ACT_PROBE, 64'hAAAA_5555_AAAA_5555, 8'd7, '0, '0, '0, '0);
    send(ACT_PROBE, 64'hAAAA_5555_AAAA_5554, 8'd7, '0, '0, '0, '0);
    send(ACT_STORE, '1, 8'd0, '0, '0, '0, '0);
    send(ACT_PROBE, '1, 8'd0, '0, '0, '0, '0);
    send(ACT_STORE, '0, 8'd255, 16'hFFFF, -16'sd1, 8'hFF, 2'd3);
    send(ACT_PROBE, '0, 8'd255, '0, '0, '0, '0);
    send(ACT_PROBE, 64'h0123_4567_89AB_CDEF, 8'd255, '0, '0, '0, '0);
    wait_for_drain();

    // Random phases across register settings, extremes included
    run_phase(30000, 65536, 100, 1'b0, 1'b0, 1'b0);
    run_phase(0, 1, 60, 1'b0, 1'b0, 1'b0);
    run_phase(32767, 0, 50, 1'b0, 1'b0, 1'b0);
    run_phase(100, 131071, 80, 1'b1, 1'b0, 1'b1);
    run_phase(1, 3, 60, 1'b0, 1'b1, 1'b0);
    run_phase(20000, 65535, 100, 1'b0, 1'b0, 1'b0);
    run_phase($urandom_range(0, 32767), $urandom_range(2, 300), 100, 1'b0, 1'b0, 1'b0);
    run_phase(30000, 65536, 100, 1'b1, 1'b1, 1'b0);

    if (mismatch_count == 0 && expected_probes.size() == 0) begin
      $display("direct_mapped_transposition_table_unit verification clean");
    end else begin
      $display("direct_mapped_transposition_table_unit verification failed");
    end
    $finish;
  end

endmodule
